FILE: hw/rtl/housekeeping_report_scheduler_assert.svh
// Assertion macros for the housekeeping report scheduler.
// Each macro relies on clk and rst_n in the scope where it is used.
`ifndef HOUSEKEEPING_REPORT_SCHEDULER_ASSERT_SVH
`define HOUSEKEEPING_REPORT_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS
`define HKRS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hkrs implication violated");
`define HKRS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hkrs invariant violated");
`else
`define HKRS_ASSERT_IMPLY(lbl, ante, cons)
`define HKRS_ASSERT_ALWAYS(lbl, expr)
`endif

`endif

FILE: hw/rtl/hkrs_pkg.sv
`default_nettype none

package hkrs_pkg;

    localparam int TABLE_DEPTH    = 32;
    localparam int MAX_DATA_BYTES = 256;
    localparam int SIZE_LIMIT     = MAX_DATA_BYTES - 2;
    localparam int ADDR_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W      = 6;

    typedef enum logic [2:0] {
        K_CLEAR    = 3'd0,
        K_APPEND   = 3'd1,
        K_START    = 3'd2,
        K_TICK     = 3'd3,
        K_ENABLE   = 3'd4,
        K_DISABLE  = 3'd5,
        K_SET_RATE = 3'd6,
        K_REPORT   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_INVALID     = 3'd1,
        STS_NOT_INIT    = 3'd2,
        STS_NOT_FOUND   = 3'd3,
        STS_BAD_VALUE   = 3'd4,
        STS_FULL        = 3'd5,
        STS_NONE_DUE    = 3'd6,
        STS_WRONG_PHASE = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH,
        S_SRCH_CMP,
        S_DIV,
        S_FOUND,
        S_SWP_RD,
        S_SWP_WR,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_END
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] hkid;
        logic [15:0] rate;
        logic [7:0]  size;
        logic        enable;
    } cmd_t;

    typedef struct packed {
        status_t                status_code;
        logic [15:0]            report_id;
        logic [OUT_IDX_W-1:0]   entry_index;
        logic [15:0]            entry_rate;
        logic [7:0]             entry_size;
        logic                   entry_enabled;
        logic                   last;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hkrs_if.sv
`default_nettype none

interface hkrs_cmd_if;
    logic              valid;
    logic              ready;
    hkrs_pkg::cmd_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hkrs_res_if;
    logic              valid;
    logic              ready;
    hkrs_pkg::res_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/housekeeping_report_scheduler.sv
// Housekeeping report scheduler.
// cmd: one command transaction per item (kind, hkid, rate, size, enable).
// res: one or more result transactions per command; last marks the final one.
// One command is worked at a time; cmd.ready is high only while idle.
// Clear, append, start failures, phase errors and other rejected commands are
// answered straight from the dispatch state; id lookups run a binary search (at
// most log2(depth)+1 steps); set rate adds a serial remainder of the 32-bit tick
// count by the new rate.
// Start and enable/disable of all entries walk the table entry by entry (read,
// then write back). A tick walks it the same way and gives its last result at
// the end of the walk. The table memory has one registered read port and one
// write port.
// Each entry keeps the tick count modulo its rate, updated on every tick.
// Reset empties the table, disarms and zeroes the tick count; no clearing
// pass is needed. When res is stalled, the block holds its result in the
// output register; the command stops at its next result until it is taken.
`default_nettype none
`include "housekeeping_report_scheduler_assert.svh"

module housekeeping_report_scheduler (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hkrs_cmd_if.sink   cmd,
    hkrs_res_if.source res
);

    localparam int ADDR_W = hkrs_pkg::ADDR_W;
    localparam int CNT_W  = hkrs_pkg::CNT_W;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] rate;
        logic [7:0]  size;
        logic        en;
        logic [15:0] rem;
    } entry_t;

    function automatic hkrs_pkg::res_t mk_res(hkrs_pkg::status_t st, logic [15:0] id,
                                              logic [ADDR_W-1:0] idx, entry_t e,
                                              logic with_entry, logic lst);
        hkrs_pkg::res_t r;
        r.status_code   = st;
        r.report_id     = id;
        r.entry_index   = with_entry ? hkrs_pkg::OUT_IDX_W'(idx) : '0;
        r.entry_rate    = with_entry ? e.rate : '0;
        r.entry_size    = with_entry ? e.size : '0;
        r.entry_enabled = with_entry ? e.en : 1'b0;
        r.last          = lst;
        return r;
    endfunction

    entry_t mem_r [hkrs_pkg::TABLE_DEPTH];
    entry_t rd_reg;
    logic               mem_re, mem_we;
    logic [ADDR_W-1:0]  mem_ra, mem_wa;
    entry_t             mem_wd;

    hkrs_pkg::state_t   state_reg, state_next;
    hkrs_pkg::cmd_t     cmd_reg, cmd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [15:0]        last_id_reg, last_id_next;
    logic               lf_reg, lf_next;
    logic               armed_reg, armed_next;
    logic [31:0]        tick_reg, tick_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]   lo_reg, lo_next, end_reg, end_next;
    logic [ADDR_W-1:0]  mid_reg, mid_next;
    logic [31:0]        div_sh_reg, div_sh_next;
    logic [15:0]        div_rem_reg, div_rem_next;
    logic [4:0]         div_cnt_reg, div_cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    hkrs_pkg::res_t     pend_reg, pend_next;
    hkrs_pkg::res_t     out_reg, out_data;
    logic               out_valid_reg, out_load;
    logic               out_free;
    logic               in_tick;

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == hkrs_pkg::S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;
    assign in_tick   = (state_reg == hkrs_pkg::S_TICK_RD)
                       || (state_reg == hkrs_pkg::S_TICK_CHK)
                       || (state_reg == hkrs_pkg::S_TICK_END);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_r[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem_r[mem_ra];
        end
    end

    always_comb
    begin
        entry_t            e;
        logic              ok;
        logic              last_ent;
        logic              due;
        logic [16:0]       t17;
        logic [CNT_W:0]    msum;
        logic [16:0]       rem_inc;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        last_id_next    = last_id_reg;
        lf_next         = lf_reg;
        armed_next      = armed_reg;
        tick_next       = tick_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        end_next        = end_reg;
        mid_next        = mid_reg;
        div_sh_next     = div_sh_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_data        = mk_res(hkrs_pkg::STS_OK, cmd_reg.hkid, '0, rd_reg, 1'b0, 1'b1);
        mem_re          = 1'b0;
        mem_ra          = idx_reg;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = rd_reg;
        e               = rd_reg;
        ok              = 1'b0;
        last_ent        = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
        due             = rd_reg.en && (rd_reg.rem == 16'd0);
        t17             = {div_rem_reg, div_sh_reg[31]};
        msum            = {1'b0, lo_reg} + {1'b0, end_reg};
        rem_inc         = {1'b0, rd_reg.rem} + 17'd1;

        unique case (state_reg)
            hkrs_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.data;
                    state_next = hkrs_pkg::S_DISPATCH;
                end
            end
            hkrs_pkg::S_DISPATCH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = hkrs_pkg::S_IDLE;
                    idx_next   = '0;
                    lo_next    = '0;
                    end_next   = count_reg;
                    unique case (hkrs_pkg::kind_t'(cmd_reg.kind))
                        hkrs_pkg::K_CLEAR:
                        begin
                            out_data.report_id = '0;
                            count_next = '0;
                            lf_next    = 1'b0;
                            armed_next = 1'b0;
                            tick_next  = '0;
                        end
                        hkrs_pkg::K_APPEND:
                        begin
                            ok = ((count_reg == '0) ? (cmd_reg.hkid != 16'd0)
                                                    : (cmd_reg.hkid > last_id_reg))
                                 && (cmd_reg.rate != 16'd0) && (cmd_reg.size != 8'd0)
                                 && ({1'b0, cmd_reg.size} <= 9'(hkrs_pkg::SIZE_LIMIT));
                            if (armed_reg)
                            begin
                                out_data.status_code = hkrs_pkg::STS_WRONG_PHASE;
                            end
                            else if (count_reg >= CNT_W'(hkrs_pkg::TABLE_DEPTH))
                            begin
                                out_data.status_code = hkrs_pkg::STS_FULL;
                            end
                            else if (!ok)
                            begin
                                lf_next = 1'b1;
                                out_data.status_code = hkrs_pkg::STS_INVALID;
                            end
                            else
                            begin
                                e.id   = cmd_reg.hkid;
                                e.rate = cmd_reg.rate;
                                e.size = cmd_reg.size;
                                e.en   = cmd_reg.enable;
                                e.rem  = '0;
                                mem_we = 1'b1;
                                mem_wa = count_reg[ADDR_W-1:0];
                                mem_wd = e;
                                out_data = mk_res(hkrs_pkg::STS_OK, cmd_reg.hkid,
                                                  count_reg[ADDR_W-1:0], e, 1'b1, 1'b1);
                                count_next   = count_reg + CNT_W'(1);
                                last_id_next = cmd_reg.hkid;
                            end
                        end
                        hkrs_pkg::K_START:
                        begin
                            out_data.report_id = '0;
                            if (count_reg == '0 || lf_reg)
                            begin
                                out_data.status_code = hkrs_pkg::STS_INVALID;
                            end
                            else
                            begin
                                out_load   = 1'b0;
                                state_next = hkrs_pkg::S_SWP_RD;
                            end
                        end
                        default:
                        begin
                            if (!armed_reg)
                            begin
                                out_data.status_code = hkrs_pkg::STS_NOT_INIT;
                                if (cmd_reg.kind == hkrs_pkg::K_TICK)
                                begin
                                    out_data.report_id = '0;
                                end
                            end
                            else if (cmd_reg.kind == hkrs_pkg::K_TICK)
                            begin
                                out_load   = 1'b0;
                                state_next = hkrs_pkg::S_TICK_RD;
                            end
                            else if (cmd_reg.hkid == 16'd0
                                     && (cmd_reg.kind == hkrs_pkg::K_ENABLE
                                         || cmd_reg.kind == hkrs_pkg::K_DISABLE))
                            begin
                                out_load   = 1'b0;
                                state_next = hkrs_pkg::S_SWP_RD;
                            end
                            else if (cmd_reg.hkid == 16'd0
                                     || (cmd_reg.kind == hkrs_pkg::K_SET_RATE
                                         && cmd_reg.rate == 16'd0))
                            begin
                                out_data.status_code = hkrs_pkg::STS_BAD_VALUE;
                            end
                            else
                            begin
                                out_load   = 1'b0;
                                state_next = hkrs_pkg::S_SRCH;
                            end
                        end
                    endcase
                end
            end
            hkrs_pkg::S_SRCH:
            begin
                if (lo_reg < end_reg)
                begin
                    mem_re     = 1'b1;
                    mem_ra     = msum[ADDR_W:1];
                    mid_next   = msum[ADDR_W:1];
                    state_next = hkrs_pkg::S_SRCH_CMP;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    out_data.status_code = hkrs_pkg::STS_NOT_FOUND;
                    state_next = hkrs_pkg::S_IDLE;
                end
            end
            hkrs_pkg::S_SRCH_CMP:
            begin
                if (rd_reg.id == cmd_reg.hkid)
                begin
                    if (cmd_reg.kind == hkrs_pkg::K_SET_RATE)
                    begin
                        div_sh_next  = tick_reg;
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        state_next   = hkrs_pkg::S_DIV;
                    end
                    else
                    begin
                        state_next = hkrs_pkg::S_FOUND;
                    end
                end
                else
                begin
                    if (rd_reg.id < cmd_reg.hkid)
                    begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    else
                    begin
                        end_next = CNT_W'(mid_reg);
                    end
                    state_next = hkrs_pkg::S_SRCH;
                end
            end
            hkrs_pkg::S_DIV:
            begin
                if (t17 >= {1'b0, cmd_reg.rate})
                begin
                    t17 = t17 - {1'b0, cmd_reg.rate};
                end
                div_rem_next = t17[15:0];
                div_sh_next  = {div_sh_reg[30:0], 1'b0};
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = hkrs_pkg::S_FOUND;
                end
            end
            hkrs_pkg::S_FOUND:
            begin
                unique case (hkrs_pkg::kind_t'(cmd_reg.kind))
                    hkrs_pkg::K_ENABLE:   e.en = 1'b1;
                    hkrs_pkg::K_DISABLE:  e.en = 1'b0;
                    hkrs_pkg::K_SET_RATE:
                    begin
                        e.rate = cmd_reg.rate;
                        e.rem  = div_rem_reg;
                    end
                    default:              e = rd_reg;
                endcase
                if (out_free)
                begin
                    mem_we     = (cmd_reg.kind != hkrs_pkg::K_REPORT);
                    mem_wa     = mid_reg;
                    mem_wd     = e;
                    out_load   = 1'b1;
                    out_data   = mk_res(hkrs_pkg::STS_OK, cmd_reg.hkid, mid_reg, e,
                                        1'b1, 1'b1);
                    state_next = hkrs_pkg::S_IDLE;
                end
            end
            hkrs_pkg::S_SWP_RD:
            begin
                mem_re     = 1'b1;
                state_next = hkrs_pkg::S_SWP_WR;
            end
            hkrs_pkg::S_SWP_WR:
            begin
                if (cmd_reg.kind == hkrs_pkg::K_START)
                begin
                    e.rem = '0;
                end
                else
                begin
                    e.en = (cmd_reg.kind == hkrs_pkg::K_ENABLE);
                end
                mem_wd = e;
                if (!last_ent)
                begin
                    mem_we     = 1'b1;
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = hkrs_pkg::S_SWP_RD;
                end
                else if (out_free)
                begin
                    mem_we   = 1'b1;
                    out_load = 1'b1;
                    out_data.report_id = '0;
                    if (cmd_reg.kind == hkrs_pkg::K_START)
                    begin
                        armed_next = 1'b1;
                        tick_next  = '0;
                    end
                    state_next = hkrs_pkg::S_IDLE;
                end
            end
            hkrs_pkg::S_TICK_RD:
            begin
                mem_re     = 1'b1;
                state_next = hkrs_pkg::S_TICK_CHK;
            end
            hkrs_pkg::S_TICK_CHK:
            begin
                if (!(due && pend_valid_reg && !out_free))
                begin
                    e.rem  = ((&tick_reg) || rem_inc == {1'b0, rd_reg.rate})
                             ? 16'd0 : rem_inc[15:0];
                    mem_we = 1'b1;
                    mem_wd = e;
                    if (due)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_data = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next = mk_res(hkrs_pkg::STS_OK, rd_reg.id, idx_reg, rd_reg,
                                           1'b1, 1'b0);
                    end
                    if (last_ent)
                    begin
                        state_next = hkrs_pkg::S_TICK_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = hkrs_pkg::S_TICK_RD;
                    end
                end
            end
            hkrs_pkg::S_TICK_END:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_data      = pend_reg;
                        out_data.last = 1'b1;
                    end
                    else
                    begin
                        out_data = mk_res(hkrs_pkg::STS_NONE_DUE, '0, '0, rd_reg,
                                          1'b0, 1'b1);
                    end
                    pend_valid_next = 1'b0;
                    tick_next       = tick_reg + 32'd1;
                    state_next      = hkrs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hkrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hkrs_pkg::S_IDLE;
            count_reg      <= '0;
            lf_reg         <= 1'b0;
            armed_reg      <= 1'b0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            lf_reg         <= lf_next;
            armed_reg      <= armed_next;
            tick_reg       <= tick_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_load || (out_valid_reg && !res.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        last_id_reg <= last_id_next;
        idx_reg     <= idx_next;
        lo_reg      <= lo_next;
        end_reg     <= end_next;
        mid_reg     <= mid_next;
        div_sh_reg  <= div_sh_next;
        div_rem_reg <= div_rem_next;
        div_cnt_reg <= div_cnt_next;
        pend_reg    <= pend_next;
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    `HKRS_ASSERT_IMPLY(a_idle_no_pend, cmd.ready, !pend_valid_reg)
    `HKRS_ASSERT_IMPLY(a_nonlast_in_tick, res.valid && !res.data.last, in_tick)
    `HKRS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(hkrs_pkg::TABLE_DEPTH))
    `HKRS_ASSERT_IMPLY(a_armed_nonempty, armed_reg, count_reg != '0)

endmodule

`default_nettype wire
